// ----- src/assert_macros.svh -----
// Assertion macros used by the top level RTL of the live byte tracker.
// Each macro expands to one labeled concurrent assertion on clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that a property holds while out of reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Assert that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`endif

// ----- src/aslbt_pkg.sv -----
// Package for the live byte tracker: event and state types, codes, hash helper.
// No dependencies.
`default_nettype none
package aslbt_pkg;
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE = 2'd1;
  localparam logic [1:0] MODE_REALLOC = 2'd2;

  localparam logic [2:0] ST_IGNORED = 3'd0;
  localparam logic [2:0] ST_TRACKED = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_FREED = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [0:0] CFG_ENABLED = 1'b0;
  localparam logic [0:0] CFG_THRESHOLD = 1'b1;

  localparam logic [31:0] HASH_MUL = 32'd2654435761;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [12:0] BLK_MAX = 13'd8191;

  // Classified event handed from the front to the back.
  typedef struct packed {
    logic        do_release;
    logic        do_insert;
    logic        is_free;
    logic [47:0] rel_addr;
    logic [47:0] address;
    logic [39:0] size;
    logic [47:0] caller;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_HASH, S_RREAD, S_RCHK, S_SREAD, S_SCHK,
    S_IREAD, S_ICHK, S_LREAD, S_LCHK, S_UPD, S_OUT
  } state_t;

  function automatic logic [31:0] mul32(input logic [31:0] x);
    return x * HASH_MUL;
  endfunction
endpackage
`default_nettype wire

// ----- src/aslbt_ram.sv -----
// Generic single port RAM with registered read.
// No dependencies.
`default_nettype none
module aslbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- src/aslbt_front.sv -----
// Front end: accepts events, applies configuration filters, queues commands.
// Depends on aslbt_pkg.
`default_nettype none
module aslbt_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               enabled,
  input  wire logic [39:0]        threshold,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_mode,
  input  wire logic [47:0]        in_address,
  input  wire logic [47:0]        in_old_address,
  input  wire logic [39:0]        in_size,
  input  wire logic [47:0]        in_caller,
  output logic                    q_valid,
  input  wire logic               q_pop,
  output aslbt_pkg::cmd_t         q_cmd
);
  aslbt_pkg::cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, rd_nxt, wr_r, wr_nxt;
  aslbt_pkg::cmd_t c;
  logic push, is_rel;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = q_r[rd_r];

  always_comb begin
    is_rel = (in_mode == aslbt_pkg::MODE_REALLOC);
    c = '0;
    c.address = in_address;
    c.size = in_size;
    c.caller = in_caller;
    c.is_free = (in_mode == aslbt_pkg::MODE_FREE);
    if (enabled) begin
      if (in_mode == aslbt_pkg::MODE_FREE) begin
        c.do_release = (in_address != 48'd0);
        c.rel_addr = in_address;
      end else if (in_mode == aslbt_pkg::MODE_ALLOC || is_rel) begin
        c.do_release = is_rel && (in_old_address != 48'd0);
        c.rel_addr = in_old_address;
        c.do_insert = (in_address != 48'd0) && (in_size >= threshold);
      end
    end
  end

  always_comb begin
    wr_nxt = wr_r ^ push;
    rd_nxt = rd_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
    end
    if (push) begin
      q_r[wr_r] <= c;
    end
  end
endmodule
`default_nettype wire

// ----- src/aslbt_back.sv -----
// Back end: sequencer over the block and site tables, one RAM access a step.
// Depends on aslbt_pkg and aslbt_ram.
`default_nettype none
module aslbt_back #(
  parameter int BLOCK_DEPTH = 4096,
  parameter int SITE_DEPTH = 512,
  parameter int BLOCK_PROBES = 16,
  parameter int SITE_PROBES = 8,
  parameter int REPORT_INTERVAL = 2048
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire aslbt_pkg::cmd_t    q_cmd,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_status,
  output logic [8:0]              out_site_index,
  output logic [47:0]             out_site_live_bytes,
  output logic [12:0]             out_site_live_blocks,
  output logic [47:0]             out_site_ever_bytes,
  output logic                    out_old_freed,
  output logic                    out_report_due
);
  localparam int BW = $clog2(BLOCK_DEPTH);
  localparam int SW = $clog2(SITE_DEPTH);
  localparam int BPW = $clog2(BLOCK_PROBES + 1);
  localparam int SPW = $clog2(SITE_PROBES + 1);
  localparam int RW = $clog2(REPORT_INTERVAL + 1);
  localparam int CW = (BW > SW) ? BW : SW;

  aslbt_pkg::state_t st_r, st_nxt;
  aslbt_pkg::cmd_t cmd_r;
  logic [BW-1:0] bhome_r, bidx_r;
  logic [SW-1:0] shome_r, sidx_r;
  logic [BPW-1:0] bp_r;
  logic [SPW-1:0] sp_r;
  logic [CW:0] clr_r;
  logic [RW-1:0] rep_r;
  logic rel_phase_r, oldf_r, due_r, have_r;
  logic [2:0] status_r;
  logic [SW-1:0] site_r;

  logic ba_we, bs_we, sk_we, sv_we;
  logic [BW-1:0] b_addr;
  logic [SW-1:0] s_addr;
  logic [47:0] ba_wd, ba_rd, sk_wd, sk_rd;
  logic [39:0] bz_rd;
  logic [SW-1:0] bsite_rd;
  logic [108:0] sv_wd, sv_rd;
  logic [47:0] lb, eb, lb_n, eb_n;
  logic [12:0] lk, lk_n;
  logic [48:0] lsum, esum;
  logic [31:0] bh, sh, ah;
  logic clearing, ob_valid_r;

  aslbt_ram #(.WIDTH(48), .DEPTH(BLOCK_DEPTH)) u_baddr (
    .clk(clk), .we(ba_we), .addr(b_addr), .wdata(ba_wd), .rdata(ba_rd));
  aslbt_ram #(.WIDTH(40 + SW), .DEPTH(BLOCK_DEPTH)) u_bsize (
    .clk(clk), .we(bs_we), .addr(b_addr), .wdata({cmd_r.size, site_r}),
    .rdata({bz_rd, bsite_rd}));
  aslbt_ram #(.WIDTH(48), .DEPTH(SITE_DEPTH)) u_skey (
    .clk(clk), .we(sk_we), .addr(s_addr), .wdata(sk_wd), .rdata(sk_rd));
  aslbt_ram #(.WIDTH(109), .DEPTH(SITE_DEPTH)) u_sval (
    .clk(clk), .we(sv_we), .addr(s_addr), .wdata(sv_wd), .rdata(sv_rd));

  assign {lb, eb, lk} = sv_rd;
  assign clearing = (st_r == aslbt_pkg::S_CLEAR);
  assign bh = aslbt_pkg::mul32(q_cmd.rel_addr[35:4]);
  assign sh = aslbt_pkg::mul32(cmd_r.caller[33:2]);
  assign ah = aslbt_pkg::mul32(cmd_r.address[35:4]);

  always_comb begin
    lsum = {1'b0, lb} + {9'd0, cmd_r.size};
    esum = {1'b0, eb} + {9'd0, cmd_r.size};
    lb_n = lb;
    eb_n = eb;
    lk_n = lk;
    if (rel_phase_r) begin
      if (lb >= bz_rd) lb_n = lb - {8'd0, bz_rd};
      if (lk != 13'd0) lk_n = lk - 13'd1;
    end else begin
      lb_n = lsum[48] ? aslbt_pkg::MAX48 : lsum[47:0];
      eb_n = esum[48] ? aslbt_pkg::MAX48 : esum[47:0];
      if (lk < aslbt_pkg::BLK_MAX) lk_n = lk + 13'd1;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      aslbt_pkg::S_CLEAR: if (clr_r[CW]) st_nxt = aslbt_pkg::S_IDLE;
      aslbt_pkg::S_IDLE: if (q_valid && !ob_valid_r) st_nxt = aslbt_pkg::S_HASH;
      aslbt_pkg::S_HASH:
        st_nxt = cmd_r.do_release ? aslbt_pkg::S_RREAD :
                 cmd_r.do_insert ? aslbt_pkg::S_IREAD : aslbt_pkg::S_OUT;
      aslbt_pkg::S_RREAD: st_nxt = aslbt_pkg::S_RCHK;
      aslbt_pkg::S_RCHK:
        if (ba_rd == cmd_r.rel_addr) st_nxt = aslbt_pkg::S_LREAD;
        else if (bp_r == BPW'(BLOCK_PROBES - 1))
          st_nxt = cmd_r.do_insert ? aslbt_pkg::S_IREAD : aslbt_pkg::S_OUT;
        else st_nxt = aslbt_pkg::S_RREAD;
      aslbt_pkg::S_IREAD: st_nxt = aslbt_pkg::S_ICHK;
      aslbt_pkg::S_ICHK:
        if (ba_rd == 48'd0) st_nxt = aslbt_pkg::S_SREAD;
        else if (bp_r == BPW'(BLOCK_PROBES - 1)) st_nxt = aslbt_pkg::S_OUT;
        else st_nxt = aslbt_pkg::S_IREAD;
      aslbt_pkg::S_SREAD: st_nxt = aslbt_pkg::S_SCHK;
      aslbt_pkg::S_SCHK:
        if (sk_rd == 48'd0 || sk_rd == cmd_r.caller ||
            sp_r == SPW'(SITE_PROBES - 1)) st_nxt = aslbt_pkg::S_LREAD;
        else st_nxt = aslbt_pkg::S_SREAD;
      aslbt_pkg::S_LREAD: st_nxt = aslbt_pkg::S_LCHK;
      aslbt_pkg::S_LCHK: st_nxt = aslbt_pkg::S_UPD;
      aslbt_pkg::S_UPD:
        st_nxt = (rel_phase_r && cmd_r.do_insert) ? aslbt_pkg::S_IREAD : aslbt_pkg::S_OUT;
      aslbt_pkg::S_OUT: st_nxt = aslbt_pkg::S_IDLE;
      default: st_nxt = aslbt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (st_r == aslbt_pkg::S_IDLE) && q_valid && !ob_valid_r;
    ba_we = 1'b0;
    bs_we = 1'b0;
    sk_we = 1'b0;
    sv_we = 1'b0;
    ba_wd = 48'd0;
    sk_wd = cmd_r.caller;
    sv_wd = {lb_n, eb_n, lk_n};
    b_addr = bidx_r;
    s_addr = sidx_r;
    case (st_r)
      aslbt_pkg::S_CLEAR: begin
        sk_we = 1'b1;
        sv_we = 1'b1;
        sk_wd = 48'd0;
        sv_wd = '0;
        ba_we = 1'b1;
        b_addr = clr_r[BW-1:0];
        s_addr = clr_r[SW-1:0];
      end
      aslbt_pkg::S_LREAD: begin
        if (rel_phase_r) s_addr = bsite_rd;
        else begin
          sk_we = (sk_rd == 48'd0 || sk_rd == cmd_r.caller);
          ba_we = 1'b1;
          ba_wd = cmd_r.address;
          bs_we = 1'b1;
        end
        if (!rel_phase_r) s_addr = site_r;
      end
      aslbt_pkg::S_LCHK: begin
        s_addr = site_r;
      end
      aslbt_pkg::S_UPD: begin
        sv_we = 1'b1;
        s_addr = site_r;
        ba_we = rel_phase_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= aslbt_pkg::S_CLEAR;
      clr_r <= '0;
      rep_r <= '0;
      ob_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (clearing) clr_r <= clr_r + 1'b1;
      if (out_valid && !out_stall) ob_valid_r <= 1'b0;
      if (st_r == aslbt_pkg::S_OUT) ob_valid_r <= 1'b1;
      if (st_r == aslbt_pkg::S_HASH && cmd_r.do_insert) begin
        if (rep_r + 1'b1 >= RW'(REPORT_INTERVAL)) rep_r <= '0;
        else rep_r <= rep_r + 1'b1;
      end
    end
    case (st_r)
      aslbt_pkg::S_IDLE: begin
        cmd_r <= q_cmd;
        bhome_r <= bh[BW-1:0];
        bidx_r <= bh[BW-1:0];
        bp_r <= '0;
        rel_phase_r <= q_cmd.do_release;
        oldf_r <= 1'b0;
        have_r <= 1'b0;
        status_r <= aslbt_pkg::ST_IGNORED;
        due_r <= 1'b0;
      end
      aslbt_pkg::S_HASH: begin
        shome_r <= sh[SW-1:0];
        sidx_r <= sh[SW-1:0];
        sp_r <= '0;
        if (cmd_r.do_insert) due_r <= (rep_r + 1'b1 >= RW'(REPORT_INTERVAL));
        if (!cmd_r.do_release) begin
          bidx_r <= ah[BW-1:0];
          bhome_r <= ah[BW-1:0];
        end
      end
      aslbt_pkg::S_RCHK: begin
        if (ba_rd == cmd_r.rel_addr) begin
          status_r <= aslbt_pkg::ST_FREED;
          oldf_r <= !cmd_r.is_free;
          have_r <= 1'b1;
        end else if (bp_r == BPW'(BLOCK_PROBES - 1)) begin
          status_r <= aslbt_pkg::ST_NOTFOUND;
          rel_phase_r <= 1'b0;
          bidx_r <= ah[BW-1:0];
          bp_r <= '0;
        end else begin
          bidx_r <= bidx_r + 1'b1;
          bp_r <= bp_r + 1'b1;
        end
      end
      aslbt_pkg::S_LREAD: if (rel_phase_r) site_r <= bsite_rd;
      aslbt_pkg::S_ICHK: begin
        if (ba_rd != 48'd0) begin
          bidx_r <= bidx_r + 1'b1;
          bp_r <= bp_r + 1'b1;
          if (bp_r == BPW'(BLOCK_PROBES - 1)) begin
            status_r <= aslbt_pkg::ST_FULL;
            have_r <= 1'b0;
          end
        end
      end
      aslbt_pkg::S_SCHK: begin
        if (sk_rd == 48'd0 || sk_rd == cmd_r.caller) site_r <= sidx_r;
        else if (sp_r == SPW'(SITE_PROBES - 1)) site_r <= shome_r;
        else begin
          sidx_r <= sidx_r + 1'b1;
          sp_r <= sp_r + 1'b1;
        end
      end
      aslbt_pkg::S_UPD: begin
        if (!rel_phase_r) begin
          status_r <= aslbt_pkg::ST_TRACKED;
          have_r <= 1'b1;
        end
        rel_phase_r <= 1'b0;
        bidx_r <= rel_phase_r ? ah[BW-1:0] : bhome_r;
        bp_r <= '0;
        out_site_live_bytes <= lb_n;
        out_site_ever_bytes <= eb_n;
        out_site_live_blocks <= lk_n;
      end
      aslbt_pkg::S_OUT: begin
        out_status <= status_r;
        out_old_freed <= oldf_r;
        out_report_due <= due_r;
        out_site_index <= have_r ? 9'(site_r) : 9'd0;
        if (!have_r) begin
          out_site_live_bytes <= '0;
          out_site_ever_bytes <= '0;
          out_site_live_blocks <= '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = ob_valid_r;
endmodule
`default_nettype wire

// ----- src/allocation_site_live_byte_tracker.sv -----
// Allocation site live byte tracker: block and site hash tables in RAM,
// depends on aslbt_pkg, aslbt_front, aslbt_back, aslbt_ram and assert_macros.svh.
//
// An ignored event passes from idle through the hash and output states. A
// reallocate may probe every block slot on both its release and its insert, and
// a site lookup may probe every site slot; each block or site probe is one
// registered read of a single port RAM. A new event starts only after the
// previous result beat has been taken. After reset the tables are swept one
// entry a cycle while up to two events wait in the queue. A two entry queue
// holds events ahead.
`default_nettype none
`include "assert_macros.svh"
module allocation_site_live_byte_tracker #(
  parameter int BLOCK_DEPTH = 4096,
  parameter int SITE_DEPTH = 512,
  parameter int BLOCK_PROBES = 16,
  parameter int SITE_PROBES = 8,
  parameter int REPORT_INTERVAL = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [39:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [47:0] in_address,
  input  wire logic [47:0] in_old_address,
  input  wire logic [39:0] in_size,
  input  wire logic [47:0] in_caller,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [8:0]       out_site_index,
  output logic [47:0]      out_site_live_bytes,
  output logic [12:0]      out_site_live_blocks,
  output logic [47:0]      out_site_ever_bytes,
  output logic             out_old_freed,
  output logic             out_report_due
);
  logic enabled_r;
  logic [39:0] threshold_r;
  logic q_valid, q_pop;
  aslbt_pkg::cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      threshold_r <= 40'd4096;
    end else if (cfg_we) begin
      if (cfg_index == aslbt_pkg::CFG_ENABLED) enabled_r <= cfg_data[0];
      else threshold_r <= cfg_data;
    end
  end

  aslbt_front u_front (
    .clk(clk), .rst_n(rst_n), .enabled(enabled_r), .threshold(threshold_r),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_address(in_address), .in_old_address(in_old_address), .in_size(in_size),
    .in_caller(in_caller), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd));

  aslbt_back #(
    .BLOCK_DEPTH(BLOCK_DEPTH), .SITE_DEPTH(SITE_DEPTH), .BLOCK_PROBES(BLOCK_PROBES),
    .SITE_PROBES(SITE_PROBES), .REPORT_INTERVAL(REPORT_INTERVAL)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_site_index(out_site_index), .out_site_live_bytes(out_site_live_bytes),
    .out_site_live_blocks(out_site_live_blocks),
    .out_site_ever_bytes(out_site_ever_bytes), .out_old_freed(out_old_freed),
    .out_report_due(out_report_due));

  `ASSERT_IMP(a_pop_valid, q_pop, q_valid)
  `ASSERT_IMP(a_ignored_site, out_valid && out_status == aslbt_pkg::ST_IGNORED,
    out_site_index == 9'd0 && out_site_live_blocks == 13'd0)
  `ASSERT_CLK(a_status_range, !out_valid || out_status <= aslbt_pkg::ST_NOTFOUND)
endmodule
`default_nettype wire

// ----- tb/allocation_site_live_byte_tracker_checker.sv -----
// Checker for the allocation site live byte tracker: watches the event, result
// and register ports, predicts each result and compares it as a whole.
// Depends on aslbt_pkg for the mode, status and register codes.
`default_nettype none
module allocation_site_live_byte_tracker_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [39:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [47:0] in_address,
  input  wire logic [47:0] in_old_address,
  input  wire logic [39:0] in_size,
  input  wire logic [47:0] in_caller,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [2:0]  out_status,
  input  wire logic [8:0]  out_site_index,
  input  wire logic [47:0] out_site_live_bytes,
  input  wire logic [12:0] out_site_live_blocks,
  input  wire logic [47:0] out_site_ever_bytes,
  input  wire logic        out_old_freed,
  input  wire logic        out_report_due,
  output int               mismatches,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = 4096;
  localparam int NSITE = 512;
  localparam int BLK_TRIES = 16;
  localparam int SITE_TRIES = 8;
  localparam int REPORT_EVERY = 2048;
  localparam logic [31:0] GOLDEN = 32'd2654435761;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  site_index;
    logic [47:0] live_bytes;
    logic [12:0] live_blocks;
    logic [47:0] ever_bytes;
    logic        old_freed;
    logic        report_due;
  } site_report_t;

  logic [47:0] blk_addr [NBLK];
  logic [39:0] blk_size [NBLK];
  logic [8:0]  blk_site [NBLK];
  logic [47:0] site_caller [NSITE];
  logic [47:0] site_live [NSITE];
  logic [47:0] site_ever [NSITE];
  logic [12:0] site_blocks [NSITE];
  int unsigned alloc_count;
  logic        track_on;
  logic [39:0] min_size;
  site_report_t expected_reports[$];

  initial begin
    for (int i = 0; i < NBLK; i++) begin
      blk_addr[i] = '0;
      blk_size[i] = '0;
      blk_site[i] = '0;
    end
    for (int i = 0; i < NSITE; i++) begin
      site_caller[i] = '0;
      site_live[i] = '0;
      site_ever[i] = '0;
      site_blocks[i] = '0;
    end
    alloc_count = 0;
    track_on = 1'b0;
    min_size = 40'd4096;
    mismatches = 0;
  end

  assign outstanding = expected_reports.size();

  function automatic logic [11:0] block_home(input logic [47:0] a);
    logic [31:0] p;
    p = a[35:4] * GOLDEN;
    return p[11:0];
  endfunction

  function automatic logic [8:0] site_home(input logic [47:0] c);
    logic [31:0] p;
    p = c[33:2] * GOLDEN;
    return p[8:0];
  endfunction

  function automatic logic [8:0] claim_site(input logic [47:0] c);
    logic [8:0] h;
    logic [8:0] s;
    h = site_home(c);
    for (int i = 0; i < SITE_TRIES; i++) begin
      s = h + 9'(i);
      if (site_caller[s] == '0 || site_caller[s] == c) begin
        site_caller[s] = c;
        return s;
      end
    end
    return h;
  endfunction

  function automatic logic release_addr(input logic [47:0] a, output logic [8:0] s);
    logic [11:0] h;
    logic [11:0] b;
    h = block_home(a);
    s = '0;
    for (int i = 0; i < BLK_TRIES; i++) begin
      b = h + 12'(i);
      if (blk_addr[b] == a) begin
        s = blk_site[b];
        if (site_live[s] >= {8'd0, blk_size[b]}) site_live[s] -= {8'd0, blk_size[b]};
        if (site_blocks[s] != '0) site_blocks[s]--;
        blk_addr[b] = '0;
        blk_size[b] = '0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic insert_addr(input logic [47:0] a, input logic [39:0] sz,
                                       input logic [47:0] c, output logic [8:0] s);
    logic [11:0] h;
    logic [11:0] b;
    logic [48:0] sum;
    h = block_home(a);
    s = '0;
    for (int i = 0; i < BLK_TRIES; i++) begin
      b = h + 12'(i);
      if (blk_addr[b] == '0) begin
        s = claim_site(c);
        blk_addr[b] = a;
        blk_size[b] = sz;
        blk_site[b] = s;
        sum = {1'b0, site_live[s]} + {9'd0, sz};
        site_live[s] = sum[48] ? aslbt_pkg::MAX48 : sum[47:0];
        sum = {1'b0, site_ever[s]} + {9'd0, sz};
        site_ever[s] = sum[48] ? aslbt_pkg::MAX48 : sum[47:0];
        if (site_blocks[s] < aslbt_pkg::BLK_MAX) site_blocks[s]++;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic site_report_t apply_event(input logic [1:0] md, input logic [47:0] a,
                                               input logic [47:0] old, input logic [39:0] sz,
                                               input logic [47:0] c);
    site_report_t r;
    logic        have_site;
    logic [8:0]  s;
    r = '0;
    have_site = 1'b0;
    s = '0;
    if (track_on) begin
      if (md == aslbt_pkg::MODE_FREE) begin
        if (a != '0) begin
          have_site = release_addr(a, s);
          r.status = have_site ? aslbt_pkg::ST_FREED : aslbt_pkg::ST_NOTFOUND;
        end
      end else if (md == aslbt_pkg::MODE_ALLOC || md == aslbt_pkg::MODE_REALLOC) begin
        if (md == aslbt_pkg::MODE_REALLOC && old != '0) begin
          have_site = release_addr(old, s);
          r.old_freed = have_site;
          r.status = have_site ? aslbt_pkg::ST_FREED : aslbt_pkg::ST_NOTFOUND;
        end
        if (a != '0 && sz >= min_size) begin
          have_site = insert_addr(a, sz, c, s);
          r.status = have_site ? aslbt_pkg::ST_TRACKED : aslbt_pkg::ST_FULL;
          alloc_count++;
          if (alloc_count >= REPORT_EVERY) begin
            r.report_due = 1'b1;
            alloc_count = 0;
          end
        end
      end
    end
    if (have_site) begin
      r.site_index = s;
      r.live_bytes = site_live[s];
      r.live_blocks = site_blocks[s];
      r.ever_bytes = site_ever[s];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    site_report_t want;
    site_report_t got;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == aslbt_pkg::CFG_ENABLED) track_on = cfg_data[0];
        else min_size = cfg_data;
      end
      if (in_valid && !in_stall)
        expected_reports.push_back(apply_event(in_mode, in_address, in_old_address,
                                               in_size, in_caller));
      if (out_valid && !out_stall) begin
        got = '{out_status, out_site_index, out_site_live_bytes, out_site_live_blocks,
                out_site_ever_bytes, out_old_freed, out_report_due};
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: %p", got);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, actual %p", want, got);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- tb/allocation_site_live_byte_tracker_tb.sv -----
// Top of the live byte tracker testbench: clock, reset, register writes and
// event stimulus with idle and stall phases; depends on the block, aslbt_pkg and the checker.
`default_nettype none
module allocation_site_live_byte_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [39:0] SIZE_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [39:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = '0;
  logic [47:0] in_address = '0;
  logic [47:0] in_old_address = '0;
  logic [39:0] in_size = '0;
  logic [47:0] in_caller = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [8:0]  out_site_index;
  logic [47:0] out_site_live_bytes;
  logic [12:0] out_site_live_blocks;
  logic [47:0] out_site_ever_bytes;
  logic        out_old_freed;
  logic        out_report_due;
  int          mismatches;
  int          outstanding;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          holds_asked = 0;
  int          holds_done = 0;
  int          quiet_cycles = 0;
  logic [35:0] addr_base [32];
  logic [33:0] caller_base [3];
  logic [47:0] live_addrs[$];

  allocation_site_live_byte_tracker uut (.*);
  allocation_site_live_byte_tracker_checker checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (holds_asked != holds_done) begin
        for (int i = 0; i < 400; i++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
        holds_done++;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic send(input logic [1:0] md, input logic [47:0] a, input logic [47:0] old,
                      input logic [39:0] sz, input logic [47:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= md;
    in_address <= a;
    in_old_address <= old;
    in_size <= sz;
    in_caller <= c;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [39:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [47:0] pick_addr();
    if ($urandom_range(9) == 0) return rand48();
    return {12'($urandom), addr_base[$urandom_range(31)]};
  endfunction

  function automatic logic [47:0] pick_caller();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r < 3) return rand48();
    return {14'($urandom_range(15)), caller_base[$urandom_range(2)]};
  endfunction

  function automatic logic [39:0] pick_size();
    int r;
    r = $urandom_range(9);
    if (r < 2) return SIZE_MAX;
    if (r < 4) return 40'($urandom_range(8191));
    return 40'({$urandom, $urandom});
  endfunction

  function automatic logic [47:0] take_live();
    int k;
    logic [47:0] a;
    if (live_addrs.size() == 0) return pick_addr();
    k = $urandom_range(live_addrs.size() - 1);
    a = live_addrs[k];
    live_addrs.delete(k);
    return a;
  endfunction

  task automatic random_event();
    int r;
    logic [47:0] a;
    logic [47:0] old;
    r = $urandom_range(99);
    if (live_addrs.size() > 600 && r < 45) r = 50;
    if (r < 45) begin
      a = pick_addr();
      live_addrs.push_back(a);
      send(aslbt_pkg::MODE_ALLOC, a, rand48(), pick_size(), pick_caller());
    end else if (r < 70) begin
      send(aslbt_pkg::MODE_FREE, take_live(), rand48(), pick_size(), pick_caller());
    end else if (r < 88) begin
      r = $urandom_range(9);
      old = (r == 0) ? '0 : (r == 1) ? rand48() : take_live();
      a = ($urandom_range(9) == 0) ? '0 : pick_addr();
      if (a != '0) live_addrs.push_back(a);
      send(aslbt_pkg::MODE_REALLOC, a, old, pick_size(), pick_caller());
    end else begin
      r = $urandom_range(3);
      if (r == 0) send(MODE_UNUSED, pick_addr(), rand48(), pick_size(), pick_caller());
      else if (r == 1) send(aslbt_pkg::MODE_FREE, rand48(), '0, pick_size(), pick_caller());
      else if (r == 2) send(aslbt_pkg::MODE_FREE, '0, rand48(), pick_size(), pick_caller());
      else send(aslbt_pkg::MODE_ALLOC, '0, rand48(), pick_size(), pick_caller());
    end
  endtask

  initial begin
    logic [47:0] a0;
    logic [47:0] a1;
    logic [47:0] c0;
    for (int i = 0; i < 32; i++) addr_base[i] = {4'($urandom), $urandom} | 36'h10;
    for (int i = 0; i < 3; i++) caller_base[i] = {2'($urandom), $urandom} | 34'h4;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (in_stall) @(negedge clk);

    send(aslbt_pkg::MODE_ALLOC, 48'h1230, '0, 40'd5000, 48'h4444);
    drain();
    write_reg(aslbt_pkg::CFG_ENABLED, 40'd1);
    write_reg(aslbt_pkg::CFG_THRESHOLD, 40'd4096);
    a0 = {12'hABC, addr_base[0]};
    a1 = {12'hFFF, addr_base[0]};
    c0 = {14'd1, caller_base[0]};
    send(aslbt_pkg::MODE_ALLOC, a0, '0, 40'd4096, c0);
    send(aslbt_pkg::MODE_ALLOC, a1, '0, 40'd4095, c0);
    send(aslbt_pkg::MODE_ALLOC, a1, '0, SIZE_MAX, c0);
    send(aslbt_pkg::MODE_ALLOC, 48'hFFFF_FFFF_FFFF, '0, SIZE_MAX, 48'hFFFF_FFFF_FFFF);
    send(aslbt_pkg::MODE_ALLOC, '0, '0, 40'd8192, c0);
    send(aslbt_pkg::MODE_ALLOC, 48'h40, '0, 40'd9000, '0);
    send(aslbt_pkg::MODE_ALLOC, 48'h80, '0, 40'd9000, '0);
    send(aslbt_pkg::MODE_FREE, a0, '0, '0, '0);
    send(aslbt_pkg::MODE_FREE, a0, '0, '0, '0);
    send(aslbt_pkg::MODE_FREE, '0, '0, '0, '0);
    send(aslbt_pkg::MODE_REALLOC, a0, a1, 40'd7000, c0);
    send(aslbt_pkg::MODE_REALLOC, '0, a0, 40'd7000, c0);
    send(aslbt_pkg::MODE_REALLOC, a1, '0, 40'd7000, c0);
    send(aslbt_pkg::MODE_REALLOC, a0, 48'h999_0000, 40'd10, c0);
    send(aslbt_pkg::MODE_REALLOC, '0, '0, '0, '0);
    send(MODE_UNUSED, a1, a1, SIZE_MAX, c0);
    send(aslbt_pkg::MODE_FREE, 48'hFFFF_FFFF_FFFF, '0, '0, '0);
    for (int k = 0; k < 10; k++)
      send(aslbt_pkg::MODE_ALLOC, 48'h5000, '0, SIZE_MAX, {14'(k), caller_base[1]});
    drain();
    write_reg(aslbt_pkg::CFG_THRESHOLD, '0);
    send(aslbt_pkg::MODE_ALLOC, 48'h7770, '0, '0, c0);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          send_idle_pct = 0; recv_stall_pct = 0;
          write_reg(aslbt_pkg::CFG_THRESHOLD, 40'd4096);
        end
        1: begin
          send_idle_pct = 73; recv_stall_pct = 0;
          write_reg(aslbt_pkg::CFG_THRESHOLD, '0);
        end
        2: begin
          send_idle_pct = 0; recv_stall_pct = 73;
          write_reg(aslbt_pkg::CFG_THRESHOLD, {8'($urandom_range(255)), $urandom});
        end
        default: begin
          send_idle_pct = 25; recv_stall_pct = 25;
          write_reg(aslbt_pkg::CFG_THRESHOLD, 40'd4096);
        end
      endcase
      for (int i = 0; i < 320; i++) begin
        if (ph == 2 && i == 50) holds_asked++;
        random_event();
      end
    end

    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(aslbt_pkg::CFG_THRESHOLD, SIZE_MAX);
    for (int i = 0; i < 20; i++) random_event();
    drain();
    write_reg(aslbt_pkg::CFG_ENABLED, '0);
    for (int i = 0; i < 20; i++) random_event();
    drain();
    write_reg(aslbt_pkg::CFG_ENABLED, 40'd1);
    write_reg(aslbt_pkg::CFG_THRESHOLD, '0);
    for (int i = 0; i < 60; i++)
      send(aslbt_pkg::MODE_ALLOC, {12'($urandom), addr_base[5]}, '0, 40'($urandom),
           pick_caller());
    drain();
    repeat (60) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
